[rtl/mam_pkg.sv]
package mam_pkg;

  // Geometry
  localparam int MAX_DIM    = 8;
  localparam int ELEM_WIDTH = 16;
  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int IDX_W      = 3;
  localparam int DIM_W      = 4;
  localparam int CNT_W      = ADDR_W + 1;
  localparam int PROD_W     = 2 * ELEM_WIDTH;
  localparam int RES_W      = 35;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_A_COLS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS = 3'd4;

  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_MUL = 1'b1;

  localparam logic SEL_A = 1'b0;

  typedef enum logic [1:0] {
    S_LOAD,
    S_ISSUE,
    S_WAIT,
    S_PUT
  } state_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_MUL,
    OP_PASS
  } op_t;

  // Raw dimension register to 1..MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end
    return res;
  endfunction

endpackage

[rtl/mam_in_if.sv]
interface mam_in_if;
  import mam_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         which_matrix;
  logic signed [ELEM_WIDTH-1:0] element_value;

  modport source (output valid, which_matrix, element_value, input ready);
  modport sink   (input valid, which_matrix, element_value, output ready);
endinterface

[rtl/mam_out_if.sv]
interface mam_out_if;
  import mam_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] result_value;
  logic [IDX_W-1:0]        result_row;
  logic [IDX_W-1:0]        result_col;
  logic                    dim_error;
  logic                    last_element;

  modport source (output valid, result_value, result_row, result_col, dim_error,
                  last_element, input ready);
  modport sink   (input valid, result_value, result_row, result_col, dim_error,
                  last_element, output ready);
endinterface

[rtl/mam_ram.sv]
module mam_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/matrix_add_multiply.sv]
// Load: one element transaction per cycle while loading; the element that completes
// both matrices starts the computation, and no input is taken until the last result
// element sits in the output register.
// Each result element reads the one read port of each store once per inner index in
// multiply mode and once in add or pass-through mode, then runs the multiply-accumulate path.
// Synchronous active-low reset: add mode, all dimensions 8, counts cleared.
module matrix_add_multiply (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mam_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [mam_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  mam_in_if.sink                            in_ch,
  mam_out_if.source                         out_ch
);
  import mam_pkg::*;

  // Configuration registers
  logic             mode_r;
  logic [DIM_W-1:0] a_rows_r, a_cols_r, b_rows_r, b_cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_ADD;
      a_rows_r <= DIM_W'(MAX_DIM);
      a_cols_r <= DIM_W'(MAX_DIM);
      b_rows_r <= DIM_W'(MAX_DIM);
      b_cols_r <= DIM_W'(MAX_DIM);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MODE:   mode_r   <= cfg_wdata[0];
        CFG_A_ROWS: a_rows_r <= cfg_wdata[DIM_W-1:0];
        CFG_A_COLS: a_cols_r <= cfg_wdata[DIM_W-1:0];
        CFG_B_ROWS: b_rows_r <= cfg_wdata[DIM_W-1:0];
        CFG_B_COLS: b_cols_r <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective dimensions and totals
  logic [DIM_W-1:0] ar, ac, br, bc;
  logic [CNT_W-1:0] tot_a, tot_b;
  logic             dim_err;

  assign ar    = clamp_dim(a_rows_r);
  assign ac    = clamp_dim(a_cols_r);
  assign br    = clamp_dim(b_rows_r);
  assign bc    = clamp_dim(b_cols_r);
  assign tot_a = CNT_W'(ar) * CNT_W'(ac);
  assign tot_b = CNT_W'(br) * CNT_W'(bc);
  assign dim_err = (mode_r == MODE_ADD) ? ((ar != br) || (ac != bc)) : (ac != br);

  // Sequencer state
  state_t           state_r, state_nxt;
  op_t              op_r;
  logic [DIM_W-1:0] rr_r, rc_r, kn_r, acl_r, bcl_r;
  logic [IDX_W-1:0] row_r, col_r, k_r;
  logic [CNT_W-1:0] cnt_a_r, cnt_b_r;
  logic             done_r;

  // Load side
  logic             in_fire, wr_a, wr_b, complete;
  logic [CNT_W-1:0] cnt_a_new, cnt_b_new;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign wr_a      = in_fire && (in_ch.which_matrix == SEL_A) && (cnt_a_r < tot_a);
  assign wr_b      = in_fire && (in_ch.which_matrix != SEL_A) && (cnt_b_r < tot_b);
  assign cnt_a_new = cnt_a_r + CNT_W'(wr_a);
  assign cnt_b_new = cnt_b_r + CNT_W'(wr_b);
  assign complete  = in_fire && (cnt_a_new >= tot_a) && (cnt_b_new >= tot_b);

  // Element position
  logic issue, k_last, col_last, row_last, put_fire;

  assign k_last   = ({1'b0, k_r}   == kn_r - DIM_W'(1));
  assign col_last = ({1'b0, col_r} == rc_r - DIM_W'(1));
  assign row_last = ({1'b0, row_r} == rr_r - DIM_W'(1));

  // Read addresses: row-major index into each store
  logic [ADDR_W:0]  a_lin, b_lin;
  logic [IDX_W-1:0] a_off;
  logic [ADDR_W-1:0] raddr_a, raddr_b;

  assign a_off = (op_r == OP_MUL) ? k_r : col_r;
  assign a_lin = (ADDR_W+1)'(row_r) * (ADDR_W+1)'(acl_r) + (ADDR_W+1)'(a_off);
  assign b_lin = ((op_r == OP_MUL) ? (ADDR_W+1)'(k_r) : (ADDR_W+1)'(row_r))
               * (ADDR_W+1)'(bcl_r) + (ADDR_W+1)'(col_r);
  assign raddr_a = a_lin[ADDR_W-1:0];
  assign raddr_b = b_lin[ADDR_W-1:0];

  // Stores
  logic [ELEM_WIDTH-1:0] rd_a, rd_b;

  mam_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_store_a (
    .clk   (clk),
    .we    (wr_a),
    .waddr (cnt_a_r[ADDR_W-1:0]),
    .wdata (in_ch.element_value),
    .raddr (raddr_a),
    .rdata (rd_a)
  );

  mam_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_store_b (
    .clk   (clk),
    .we    (wr_b),
    .waddr (cnt_b_r[ADDR_W-1:0]),
    .wdata (in_ch.element_value),
    .raddr (raddr_b),
    .rdata (rd_b)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD:  if (complete) state_nxt = S_ISSUE;
      S_ISSUE: if (k_last) state_nxt = S_WAIT;
      S_WAIT:  if (done_r) state_nxt = S_PUT;
      S_PUT:   if (put_fire) state_nxt = (row_last && col_last) ? S_LOAD : S_ISSUE;
      default: state_nxt = S_LOAD;
    endcase
  end

  // State outputs
  logic out_valid_r;

  always_comb begin
    in_ch.ready = 1'b0;
    issue       = 1'b0;
    put_fire    = 1'b0;
    case (state_r)
      S_LOAD:  in_ch.ready = 1'b1;
      S_ISSUE: issue = 1'b1;
      S_PUT:   put_fire = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  // Counters, operation latch and position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      row_r   <= '0;
      col_r   <= '0;
      k_r     <= '0;
      op_r    <= OP_ADD;
    end else begin
      state_r <= state_nxt;
      if (complete) begin
        cnt_a_r <= '0;
        cnt_b_r <= '0;
        row_r   <= '0;
        col_r   <= '0;
        k_r     <= '0;
        op_r    <= dim_err ? OP_PASS : ((mode_r == MODE_MUL) ? OP_MUL : OP_ADD);
      end else begin
        cnt_a_r <= cnt_a_new;
        cnt_b_r <= cnt_b_new;
      end
      if (issue) begin
        k_r <= k_last ? '0 : k_r + IDX_W'(1);
      end
      if (put_fire) begin
        if (col_last) begin
          col_r <= '0;
          row_r <= row_r + IDX_W'(1);
        end else begin
          col_r <= col_r + IDX_W'(1);
        end
      end
    end
  end

  // Loop bounds for this result, held while busy
  always_ff @(posedge clk) begin
    if (complete) begin
      rr_r  <= ar;
      rc_r  <= (dim_err || mode_r == MODE_ADD) ? ac : bc;
      kn_r  <= (!dim_err && mode_r == MODE_MUL) ? ac : DIM_W'(1);
      acl_r <= ac;
      bcl_r <= bc;
    end
  end

  // Datapath: read -> operate -> accumulate
  logic v1_r, first1_r, last1_r;
  logic v2_r, first2_r, last2_r;
  logic signed [ELEM_WIDTH-1:0] a_s, b_s;
  logic signed [PROD_W-1:0]     prod_c;
  logic signed [RES_W-1:0]      val_c, val2_r, acc_r;

  assign a_s    = rd_a;
  assign b_s    = rd_b;
  assign prod_c = a_s * b_s;

  always_comb begin
    case (op_r)
      OP_MUL:  val_c = RES_W'(prod_c);
      OP_ADD:  val_c = RES_W'(a_s) + RES_W'(b_s);
      default: val_c = RES_W'(a_s);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= issue;
      v2_r   <= v1_r;
      done_r <= v2_r && last2_r;
    end
  end

  always_ff @(posedge clk) begin
    first1_r <= (k_r == '0);
    last1_r  <= k_last;
    first2_r <= first1_r;
    last2_r  <= last1_r;
    val2_r   <= val_c;
    if (v2_r) begin
      acc_r <= first2_r ? val2_r : acc_r + val2_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (put_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put_fire) begin
      out_ch.result_value <= acc_r;
      out_ch.result_row   <= row_r;
      out_ch.result_col   <= col_r;
      out_ch.dim_error    <= (op_r == OP_PASS);
      out_ch.last_element <= row_last && col_last;
    end
  end

  assign out_ch.valid = out_valid_r;

  // Checks
  a_idle_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> (!v1_r && !v2_r && !done_r))
    else $error("pipeline busy while loading");

  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (state_r == S_WAIT))
    else $error("accumulator finished outside wait state");

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ISSUE) |-> ({1'b0, k_r} < kn_r))
    else $error("inner index beyond its bound");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_a_r <= CNT_W'(DEPTH)) && (cnt_b_r <= CNT_W'(DEPTH)))
    else $error("load count beyond store depth");

  a_last_out: assert property (@(posedge clk) disable iff (!rst_n)
    (put_fire && row_last && col_last) |=> (out_ch.last_element && state_r == S_LOAD))
    else $error("final transaction not flagged");

endmodule

[sim/mam_tb_pkg.sv]
`timescale 1ns / 100ps

package mam_tb_pkg;
  import mam_pkg::*;

  localparam logic SEL_B = !SEL_A;

  localparam logic signed [ELEM_WIDTH-1:0] ELEM_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
  localparam logic signed [ELEM_WIDTH-1:0] ELEM_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};

  // One element of the result matrix as seen on the output channel
  typedef struct packed {
    logic signed [RES_W-1:0] value;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic                    dim_error;
    logic                    is_last;
  } mam_result_t;

  // Shadow of the block: register copies, both stores, load counts and the
  // queue of result elements still to come out
  class mam_result_board;
    logic [CFG_DATA_W-1:0]        regs [CFG_MODE:CFG_B_COLS];
    logic signed [ELEM_WIDTH-1:0] elems_a [DEPTH];
    logic signed [ELEM_WIDTH-1:0] elems_b [DEPTH];
    int unsigned                  filled_a;
    int unsigned                  filled_b;
    mam_result_t                  expected_q [$];

    int unsigned errors;
    int unsigned checked;
    int unsigned dropped;
    int unsigned sets_add;
    int unsigned sets_mul;
    int unsigned sets_bad;

    function new();
      regs[CFG_MODE]   = CFG_DATA_W'(MODE_ADD);
      regs[CFG_A_ROWS] = CFG_DATA_W'(MAX_DIM);
      regs[CFG_A_COLS] = CFG_DATA_W'(MAX_DIM);
      regs[CFG_B_ROWS] = CFG_DATA_W'(MAX_DIM);
      regs[CFG_B_COLS] = CFG_DATA_W'(MAX_DIM);
      filled_a = 0;
      filled_b = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_MODE) begin
        regs[idx] = CFG_DATA_W'(val[0]);
      end else if (idx <= CFG_B_COLS) begin
        regs[idx] = val;
      end
    endfunction

    // Effective dimension: zero reads as one, anything above the maximum as the maximum
    function int unsigned dim(logic [CFG_IDX_W-1:0] idx);
      int unsigned raw;
      raw = regs[idx];
      if (raw == 0) return 1;
      if (raw > MAX_DIM) return MAX_DIM;
      return raw;
    endfunction

    function int unsigned total_a();
      return dim(CFG_A_ROWS) * dim(CFG_A_COLS);
    endfunction

    function int unsigned total_b();
      return dim(CFG_B_ROWS) * dim(CFG_B_COLS);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Accepted input transaction; returns 1 when the element was stored
    function bit note_element(logic sel, logic signed [ELEM_WIDTH-1:0] v);
      int unsigned             ar, ac, br, bc, n_cols;
      bit                      stored;
      bit                      is_mul;
      bit                      bad;
      logic signed [RES_W-1:0] acc;
      logic signed [PROD_W-1:0] prod;
      mam_result_t             res;
      ar = dim(CFG_A_ROWS);
      ac = dim(CFG_A_COLS);
      br = dim(CFG_B_ROWS);
      bc = dim(CFG_B_COLS);
      stored = 1'b0;

      if (sel == SEL_A) begin
        if (filled_a < ar * ac) begin
          elems_a[filled_a] = v;
          filled_a++;
          stored = 1'b1;
        end
      end else if (filled_b < br * bc) begin
        elems_b[filled_b] = v;
        filled_b++;
        stored = 1'b1;
      end
      if (!stored) dropped++;

      // completion is judged against the registers as they stand now
      if (filled_a < ar * ac || filled_b < br * bc) return stored;

      is_mul = (regs[CFG_MODE][0] == MODE_MUL);
      bad    = is_mul ? (ac != br) : (ar != br || ac != bc);
      n_cols = (bad || !is_mul) ? ac : bc;
      if (bad) sets_bad++;
      else if (is_mul) sets_mul++;
      else sets_add++;

      for (int unsigned r = 0; r < ar; r++) begin
        for (int unsigned c = 0; c < n_cols; c++) begin
          if (bad) begin
            acc = elems_a[r * ac + c];
          end else if (!is_mul) begin
            acc = elems_a[r * ac + c] + elems_b[r * bc + c];
          end else begin
            acc = '0;
            for (int unsigned k = 0; k < ac; k++) begin
              prod = elems_a[r * ac + k] * elems_b[k * bc + c];
              acc  = acc + prod;
            end
          end
          res.value     = acc;
          res.row       = IDX_W'(r);
          res.col       = IDX_W'(c);
          res.dim_error = bad;
          res.is_last   = (r == ar - 1) && (c == n_cols - 1);
          expected_q.push_back(res);
        end
      end
      filled_a = 0;
      filled_b = 0;
      return stored;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // Accepted output transaction against the oldest expected element
    task check_result(mam_result_t got);
      mam_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result (%0d,%0d) value %0d arrived with none due",
                         got.row, got.col, got.value));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.value !== want.value)
        report($sformatf("(%0d,%0d) value %0d, want %0d",
                         want.row, want.col, got.value, want.value));
      if (got.row !== want.row)
        report($sformatf("row %0d, want %0d", got.row, want.row));
      if (got.col !== want.col)
        report($sformatf("col %0d, want %0d", got.col, want.col));
      if (got.dim_error !== want.dim_error)
        report($sformatf("(%0d,%0d) dim_error %0b, want %0b",
                         want.row, want.col, got.dim_error, want.dim_error));
      if (got.is_last !== want.is_last)
        report($sformatf("(%0d,%0d) last_element %0b, want %0b",
                         want.row, want.col, got.is_last, want.is_last));
    endtask
  endclass

endpackage

[sim/tb_matrix_add_multiply.sv]
`timescale 1ns / 100ps

module tb_matrix_add_multiply;
  import mam_pkg::*;
  import mam_tb_pkg::*;

  localparam int          HALF_PERIOD   = 6;
  localparam int          RESET_CYCLES  = 6;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          SETTLE_CYCLES = 24;
  localparam int          DRAIN_CYCLES  = 200;
  localparam int          RANDOM_ITEMS  = 140;
  localparam int          CALM_ITEMS    = 110;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mam_in_if  in_ch ();
  mam_out_if out_ch ();

  mam_result_board board = new();

  bit          calm = 1'b0;
  bit          hold_armed = 1'b0;
  int unsigned holds_done = 0;
  int unsigned loaded_items = 0;
  int unsigned cycles = 0;

  matrix_add_multiply i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #HALF_PERIOD clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d result elements still due",
               cycles, board.pending());
      $display("** matrix_add_multiply: FAILED **");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off when armed, checks every transaction
  initial begin : result_sink
    mam_result_t got;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_armed && out_ch.valid) begin
        hold_armed = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      if (out_ch.valid) begin
        got.value     = out_ch.result_value;
        got.row       = out_ch.result_row;
        got.col       = out_ch.result_col;
        got.dim_error = out_ch.dim_error;
        got.is_last   = out_ch.last_element;
        board.check_result(got);
      end
    end
  end

  // Extremes often, otherwise any 16-bit pattern
  function automatic logic signed [ELEM_WIDTH-1:0] rand_elem();
    case ($urandom_range(0, 7))
      0: return ELEM_MIN;
      1: return ELEM_MAX;
      default: return ELEM_WIDTH'($urandom);
    endcase
  endfunction

  // Mostly small sizes, sometimes the maximum or an out-of-range register value
  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return DIM_W'($urandom_range(MAX_DIM + 1, (1 << DIM_W) - 1));
      2, 3: return DIM_W'(MAX_DIM);
      default: return DIM_W'($urandom_range(1, 3));
    endcase
  endfunction

  // One input transaction, with an optional idle burst before it
  task automatic send_elem(input logic sel, input logic signed [ELEM_WIDTH-1:0] v);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.which_matrix  <= sel;
    in_ch.element_value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (board.note_element(sel, v)) loaded_items++;
  endtask

  // Write all five registers; the block must be idle
  task automatic set_config(input logic m, input logic [DIM_W-1:0] ar, ac, br, bc);
    logic [CFG_DATA_W-1:0] vals [CFG_MODE:CFG_B_COLS];
    vals[CFG_MODE]   = CFG_DATA_W'(m);
    vals[CFG_A_ROWS] = ar;
    vals[CFG_A_COLS] = ac;
    vals[CFG_B_ROWS] = br;
    vals[CFG_B_COLS] = bc;
    for (int i = CFG_MODE; i <= CFG_B_COLS; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= CFG_IDX_W'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      board.write_reg(CFG_IDX_W'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both matrices in random interleave; once one is full, stray elements for it
  // are slipped in now and then and must be dropped
  task automatic load_set(input int noise_pct);
    int unsigned need_a, need_b, got_a, got_b;
    logic        sel;
    need_a = board.total_a();
    need_b = board.total_b();
    got_a  = 0;
    got_b  = 0;
    while (got_a < need_a || got_b < need_b) begin
      if (got_a == need_a || got_b == need_b) begin
        if ($urandom_range(1, 100) <= noise_pct) begin
          send_elem((got_a == need_a) ? SEL_A : SEL_B, rand_elem());
          continue;
        end
        sel = (got_a < need_a) ? SEL_A : SEL_B;
      end else begin
        sel = $urandom_range(0, 1) ? SEL_B : SEL_A;
      end
      send_elem(sel, rand_elem());
      if (sel == SEL_A) got_a++;
      else got_b++;
    end
  endtask

  // Random setting, mostly with fitting sizes, then one to three result sets
  task automatic random_phase(input int n_sets);
    logic             m;
    logic [DIM_W-1:0] ar, ac, br, bc;
    m  = $urandom_range(0, 1) ? MODE_MUL : MODE_ADD;
    ar = pick_dim();
    ac = pick_dim();
    if ($urandom_range(0, 3) != 0) begin
      br = (m == MODE_MUL) ? ac : ar;
      bc = (m == MODE_MUL) ? pick_dim() : ac;
    end else begin
      br = pick_dim();
      bc = pick_dim();
    end
    set_config(m, ar, ac, br, bc);
    if (board.total_a() + board.total_b() > 40) n_sets = 1;
    repeat (n_sets) load_set(15);
    wait_idle();
  endtask

  initial begin : stimulus
    int unsigned base;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= CFG_MODE;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.which_matrix  <= SEL_A;
    in_ch.element_value <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Add at the value extremes; zero rows read as one; a stray A element is dropped
    set_config(MODE_ADD, '0, 4'd2, '0, 4'd2);
    send_elem(SEL_A, ELEM_MAX);
    send_elem(SEL_A, ELEM_MIN);
    send_elem(SEL_A, 16'sd5);
    send_elem(SEL_B, ELEM_MAX);
    send_elem(SEL_B, ELEM_MIN);
    wait_idle();

    // Outer product: rows come from A, columns from B
    set_config(MODE_MUL, 4'd2, 4'd1, 4'd1, 4'd2);
    send_elem(SEL_A, ELEM_MIN);
    send_elem(SEL_B, ELEM_MIN);
    send_elem(SEL_A, ELEM_MAX);
    send_elem(SEL_B, ELEM_MAX);
    wait_idle();

    // Multiply with inner sizes that differ: A passes through flagged
    set_config(MODE_MUL, 4'd1, 4'd2, 4'd1, 4'd1);
    send_elem(SEL_A, -16'sd1);
    send_elem(SEL_B, 16'sd7);
    send_elem(SEL_A, 16'sd12345);
    wait_idle();

    // Add with sizes that differ, A rows above the maximum read as eight
    set_config(MODE_ADD, 4'd9, 4'd1, 4'd1, 4'd1);
    load_set(0);
    wait_idle();

    // A half loaded, then its rows cut to one; the next transaction completes it
    set_config(MODE_MUL, 4'd2, 4'd1, 4'd1, 4'd1);
    send_elem(SEL_A, 16'sd300);
    send_elem(SEL_B, -16'sd200);
    wait_idle();
    set_config(MODE_MUL, 4'd1, 4'd1, 4'd1, 4'd1);
    send_elem(SEL_B, 16'sd1);
    wait_idle();

    // Random part; the first result holds off the receiver while further sets queue
    base = loaded_items;
    set_config(MODE_MUL, 4'd2, 4'd3, 4'd3, 4'd2);
    hold_armed = 1'b1;
    repeat (3) load_set(15);
    wait_idle();
    while (loaded_items - base < RANDOM_ITEMS) begin
      if (loaded_items - base >= CALM_ITEMS) calm = 1'b1;
      random_phase($urandom_range(1, 3));
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.pending() != 0)
      board.report($sformatf("%0d result elements never came out", board.pending()));

    $display("Loaded %0d elements and dropped %0d strays over %0d add, %0d multiply",
             loaded_items, board.dropped, board.sets_add, board.sets_mul);
    $display("and %0d size-mismatch sets; checked %0d result elements; %0d long hold-off(s).",
             board.sets_bad, board.checked, holds_done);
    if (board.errors == 0) begin
      $display("** matrix_add_multiply: PASSED **");
    end else begin
      $display("** matrix_add_multiply: FAILED **");
    end
    $finish;
  end

endmodule
